// ===== rtl/asgr_pkg.sv =====
package asgr_pkg;

   localparam int MAX_COLS   = 256;
   localparam int MAX_ROWS   = 128;
   localparam int MAX_PARAMS = 16;

   // largest values the cursor registers can compare against
   localparam int COL_CAP = (MAX_COLS > 511) ? 511 : MAX_COLS;
   localparam int ROW_CAP = (MAX_ROWS > 255) ? 255 : MAX_ROWS;

   localparam int COL_W = 9;
   localparam int ROW_W = 8;
   localparam int NUM_W = 16;
   localparam int RGB_W = 24;

   localparam logic [COL_W-1:0] COL_LIMIT  = 9'd511;
   localparam logic [NUM_W-1:0] NUM_LIMIT  = 16'hFFFF;
   localparam logic [RGB_W-1:0] FG_DEFAULT = 24'hC8C8DC;
   localparam logic [RGB_W-1:0] BG_DEFAULT = 24'h101020;

   localparam logic [8:0] COLS_RESET = 9'd100;
   localparam logic [7:0] ROWS_RESET = 8'd37;

   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_CUP      = 8'h48;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_SGR      = 8'h6D;

   localparam logic [NUM_W-1:0] SGR_RESET      = 16'd0;
   localparam logic [NUM_W-1:0] SGR_TRUECOLOUR = 16'd2;
   localparam logic [NUM_W-1:0] SGR_FG_EXT     = 16'd38;
   localparam logic [NUM_W-1:0] SGR_BG_EXT     = 16'd48;

   localparam logic [0:0] CSR_COLS = 1'b0;
   localparam logic [0:0] CSR_ROWS = 1'b1;

   typedef enum logic [1:0] {
      PH_TEXT,
      PH_ESC,
      PH_CSI
   } phase_type;

   typedef enum logic [2:0] {
      WK_IDLE,
      WK_FETCH,
      WK_CODE,
      WK_SEL,
      WK_RED,
      WK_GRN,
      WK_BLU
   } walk_state_type;

   typedef struct packed {
      logic             fg_wr;
      logic             bg_wr;
      logic             dflt;
      logic [RGB_W-1:0] rgb;
   } colour_upd_type;

endpackage

// ===== rtl/asgr_param_store.sv =====
module asgr_param_store #(
   parameter int DEPTH = asgr_pkg::MAX_PARAMS,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [asgr_pkg::NUM_W-1:0]  wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [asgr_pkg::NUM_W-1:0]  rd_data
);

   logic [asgr_pkg::NUM_W-1:0] mem [DEPTH];
   logic [asgr_pkg::NUM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/asgr_sgr_walker.sv =====
module asgr_sgr_walker #(
   parameter int MAX_PARAMS = asgr_pkg::MAX_PARAMS,
   parameter int CW         = $clog2(MAX_PARAMS + 1),
   parameter int AW         = $clog2(MAX_PARAMS)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [CW-1:0]                  count,
   input  logic [asgr_pkg::NUM_W-1:0]     rd_data,
   output logic [AW-1:0]                  rd_addr,
   output logic                           busy,
   output asgr_pkg::colour_upd_type       upd
);

   asgr_pkg::walk_state_type state_ff, state_in;

   logic [CW-1:0]              p_ff, p_in;
   logic [asgr_pkg::NUM_W-1:0] code_ff, code_in;
   logic                       full_ff, full_in;
   logic [7:0]                 red_ff, red_in;
   logic [7:0]                 grn_ff, grn_in;

   logic [2:0]  offset;
   logic [CW:0] sum;
   logic        is_ext;
   logic        take;
   logic        more;

   // shared index adder: every store address and every step of p
   assign sum    = {1'b0, p_ff} + {{(CW - 2){1'b0}}, offset};
   assign rd_addr = sum[AW-1:0];

   assign is_ext = (code_ff == asgr_pkg::SGR_FG_EXT) || (code_ff == asgr_pkg::SGR_BG_EXT);
   assign take   = is_ext && full_ff && (rd_data == asgr_pkg::SGR_TRUECOLOUR);
   assign more   = p_ff < count;
   assign busy   = state_ff != asgr_pkg::WK_IDLE;

   always_comb begin
      case (state_ff)
         asgr_pkg::WK_CODE: offset = 3'd1;
         asgr_pkg::WK_SEL:  offset = take ? 3'd2 : 3'd1;
         asgr_pkg::WK_RED:  offset = 3'd3;
         asgr_pkg::WK_GRN:  offset = 3'd4;
         asgr_pkg::WK_BLU:  offset = 3'd5;
         default:           offset = 3'd0;
      endcase
   end

   // next state
   always_comb begin
      case (state_ff)
         asgr_pkg::WK_IDLE:  state_in = start ? asgr_pkg::WK_FETCH : asgr_pkg::WK_IDLE;
         asgr_pkg::WK_FETCH: state_in = more ? asgr_pkg::WK_CODE : asgr_pkg::WK_IDLE;
         asgr_pkg::WK_CODE:  state_in = asgr_pkg::WK_SEL;
         asgr_pkg::WK_SEL:   state_in = take ? asgr_pkg::WK_RED : asgr_pkg::WK_FETCH;
         asgr_pkg::WK_RED:   state_in = asgr_pkg::WK_GRN;
         asgr_pkg::WK_GRN:   state_in = asgr_pkg::WK_BLU;
         asgr_pkg::WK_BLU:   state_in = asgr_pkg::WK_FETCH;
         default:            state_in = asgr_pkg::WK_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      p_in    = p_ff;
      code_in = code_ff;
      full_in = full_ff;
      red_in  = red_ff;
      grn_in  = grn_ff;
      upd     = '0;
      case (state_ff)
         asgr_pkg::WK_IDLE: begin
            if (start) begin
               p_in = '0;
            end
         end
         asgr_pkg::WK_CODE: begin
            code_in = rd_data;
            full_in = ({1'b0, p_ff} + (CW + 1)'(4)) < {1'b0, count};
         end
         asgr_pkg::WK_SEL: begin
            if (!take) begin
               p_in     = sum[CW-1:0];
               upd.dflt = code_ff == asgr_pkg::SGR_RESET;
            end
         end
         asgr_pkg::WK_RED: begin
            red_in = rd_data[7:0];
         end
         asgr_pkg::WK_GRN: begin
            grn_in = rd_data[7:0];
         end
         asgr_pkg::WK_BLU: begin
            p_in      = sum[CW-1:0];
            upd.fg_wr = code_ff == asgr_pkg::SGR_FG_EXT;
            upd.bg_wr = code_ff != asgr_pkg::SGR_FG_EXT;
            upd.rgb   = {red_ff, grn_ff, rd_data[7:0]};
         end
         default: begin
            p_in = p_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= asgr_pkg::WK_IDLE;
         p_ff     <= '0;
      end else begin
         state_ff <= state_in;
         p_ff     <= p_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      full_ff <= full_in;
      red_ff  <= red_in;
      grn_ff  <= grn_in;
   end

endmodule

// ===== rtl/ansi_sgr_cell_parser.sv =====
// Terminal text parser: takes one byte per transaction and returns one cell write
// (column, row, glyph and both colours) for each byte other than ESC, LF, CR, TAB
// that lands inside the active columns; those control bytes and escape sequences
// update the cursor and colours silently. req_tready is low only while a cell
// write waits and during the walk, after the 'm' that ends an SGR sequence, over
// the stored parameters through the single read port of the parameter store:
// fetch, code and select steps per plain parameter, plus red, green and blue
// steps per 38;2;r;g;b or 48;2;r;g;b group, and a final fetch. Once the cursor
// row reaches the row count every byte is dropped until a transaction with
// frame_start set. The column and row registers may be written at any idle
// time; values above the build limits are clipped to them (rows to 8 bits first).
module ansi_sgr_cell_parser #(
   parameter int MAX_PARAMS = asgr_pkg::MAX_PARAMS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // cell_column, cell_row, glyph, fg_red, fg_green,
                                    // fg_blue, bg_red, bg_green, bg_blue, zero pad
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [8:0]  csr_wdata
);

   localparam int CW = $clog2(MAX_PARAMS + 1);
   localparam int AW = $clog2(MAX_PARAMS);

   logic [8:0]                   active_cols_ff;
   logic [7:0]                   active_rows_ff;
   logic [asgr_pkg::COL_W-1:0]   col_ff, col_in, col_b;
   logic [asgr_pkg::ROW_W-1:0]   row_ff, row_in, row_b;
   logic [asgr_pkg::RGB_W-1:0]   fg_ff, fg_in, fg_b;
   logic [asgr_pkg::RGB_W-1:0]   bg_ff, bg_in, bg_b;
   asgr_pkg::phase_type          phase_ff, phase_in, phase_b;
   logic [asgr_pkg::NUM_W-1:0]   accum_ff, accum_in, accum_b;
   logic                         in_num_ff, in_num_in, in_num_b;
   logic [CW-1:0]                count_ff, count_in, count_b;
   logic                         halted_ff, halted_in, halted_b;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [71:0]                  rsp_data_ff;

   logic                         accept;
   logic                         fs;
   logic [7:0]                   b;
   logic [8:0]                   cols_used;
   logic [7:0]                   rows_used;
   logic [asgr_pkg::ROW_W-1:0]   row_inc;
   logic [9:0]                   tab_sum;
   logic [asgr_pkg::COL_W-1:0]   col_adv;
   logic [19:0]                  prod;
   logic                         emit;
   logic                         wr_en;
   logic                         start;
   logic [AW-1:0]                rd_addr;
   logic [asgr_pkg::NUM_W-1:0]   rd_data;
   logic                         busy;
   asgr_pkg::colour_upd_type     upd;

   asgr_param_store #(
      .DEPTH (MAX_PARAMS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_b[AW-1:0]),
      .wr_data (accum_b),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   asgr_sgr_walker #(
      .MAX_PARAMS (MAX_PARAMS),
      .CW         (CW),
      .AW         (AW)
   ) u_walker (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .count   (count_ff),
      .rd_data (rd_data),
      .rd_addr (rd_addr),
      .busy    (busy),
      .upd     (upd)
   );

   assign req_tready = !busy && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign fs         = req_tuser;
   assign b          = req_tdata;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign cols_used = ({23'd0, active_cols_ff} > asgr_pkg::COL_CAP) ?
                      9'(asgr_pkg::COL_CAP) : active_cols_ff;
   assign rows_used = ({24'd0, active_rows_ff} > asgr_pkg::ROW_CAP) ?
                      8'(asgr_pkg::ROW_CAP) : active_rows_ff;

   // state as seen after an optional frame clear
   assign col_b    = fs ? '0 : col_ff;
   assign row_b    = fs ? '0 : row_ff;
   assign fg_b     = fs ? asgr_pkg::FG_DEFAULT : fg_ff;
   assign bg_b     = fs ? asgr_pkg::BG_DEFAULT : bg_ff;
   assign phase_b  = fs ? asgr_pkg::PH_TEXT : phase_ff;
   assign accum_b  = fs ? '0 : accum_ff;
   assign in_num_b = fs ? 1'b0 : in_num_ff;
   assign count_b  = fs ? '0 : count_ff;
   assign halted_b = fs ? 1'b0 : halted_ff;

   assign row_inc = row_b + 8'd1;
   assign tab_sum = {1'b0, col_b} + 10'd8;
   assign col_adv = (col_b < asgr_pkg::COL_LIMIT) ? col_b + 9'd1 : col_b;
   assign prod    = {1'b0, accum_b, 3'b000} + {3'b000, accum_b, 1'b0}
                    + {12'd0, b - asgr_pkg::CH_ZERO};

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      fg_in     = upd.fg_wr ? upd.rgb : (upd.dflt ? asgr_pkg::FG_DEFAULT : fg_ff);
      bg_in     = upd.bg_wr ? upd.rgb : (upd.dflt ? asgr_pkg::BG_DEFAULT : bg_ff);
      phase_in  = phase_ff;
      accum_in  = accum_ff;
      in_num_in = in_num_ff;
      count_in  = count_ff;
      halted_in = halted_ff;
      emit      = 1'b0;
      wr_en     = 1'b0;
      start     = 1'b0;
      if (accept) begin
         col_in    = col_b;
         row_in    = row_b;
         fg_in     = fg_b;
         bg_in     = bg_b;
         phase_in  = phase_b;
         accum_in  = accum_b;
         in_num_in = in_num_b;
         count_in  = count_b;
         halted_in = halted_b;
         if (halted_b || (row_b >= rows_used)) begin
            halted_in = 1'b1;
         end else begin
            case (phase_b)
               asgr_pkg::PH_ESC: begin
                  if (b == asgr_pkg::CH_LBRACKET) begin
                     phase_in  = asgr_pkg::PH_CSI;
                     count_in  = '0;
                     accum_in  = '0;
                     in_num_in = 1'b0;
                  end else begin
                     phase_in = asgr_pkg::PH_TEXT;
                  end
               end
               asgr_pkg::PH_CSI: begin
                  if ((b >= asgr_pkg::CH_ZERO) && (b <= asgr_pkg::CH_NINE)) begin
                     accum_in  = (prod > {4'd0, asgr_pkg::NUM_LIMIT}) ?
                                 asgr_pkg::NUM_LIMIT : prod[15:0];
                     in_num_in = 1'b1;
                  end else begin
                     if (in_num_b) begin
                        if (count_b < CW'(MAX_PARAMS)) begin
                           wr_en    = 1'b1;
                           count_in = count_b + CW'(1);
                        end
                        in_num_in = 1'b0;
                        accum_in  = '0;
                     end
                     if (b == asgr_pkg::CH_SGR) begin
                        phase_in = asgr_pkg::PH_TEXT;
                        start    = 1'b1;
                     end else if (b == asgr_pkg::CH_CUP) begin
                        phase_in = asgr_pkg::PH_TEXT;
                     end
                  end
               end
               default: begin
                  if (b == asgr_pkg::CH_ESC) begin
                     phase_in = asgr_pkg::PH_ESC;
                  end else if (b == asgr_pkg::CH_LF) begin
                     col_in    = '0;
                     row_in    = row_inc;
                     halted_in = row_inc >= rows_used;
                  end else if (b == asgr_pkg::CH_CR) begin
                     col_in = '0;
                  end else if (b == asgr_pkg::CH_TAB) begin
                     col_in = tab_sum[9] ? asgr_pkg::COL_LIMIT : {tab_sum[8:3], 3'b000};
                  end else begin
                     emit = col_b < cols_used;
                     if (col_adv >= cols_used) begin
                        col_in    = '0;
                        row_in    = row_inc;
                        halted_in = row_inc >= rows_used;
                     end else begin
                        col_in = col_adv;
                     end
                  end
               end
            endcase
         end
      end
   end

   always_comb begin
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_cols_ff <= asgr_pkg::COLS_RESET;
         active_rows_ff <= asgr_pkg::ROWS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            asgr_pkg::CSR_COLS: active_cols_ff <= csr_wdata;
            asgr_pkg::CSR_ROWS: active_rows_ff <= csr_wdata[7:0];
            default:            active_cols_ff <= active_cols_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         fg_ff        <= asgr_pkg::FG_DEFAULT;
         bg_ff        <= asgr_pkg::BG_DEFAULT;
         phase_ff     <= asgr_pkg::PH_TEXT;
         accum_ff     <= '0;
         in_num_ff    <= 1'b0;
         count_ff     <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         phase_ff     <= phase_in;
         accum_ff     <= accum_in;
         in_num_ff    <= in_num_in;
         count_ff     <= count_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_data_ff <= {1'b0,
                         bg_b[7:0], bg_b[15:8], bg_b[23:16],
                         fg_b[7:0], fg_b[15:8], fg_b[23:16],
                         b, row_b[6:0], col_b[7:0]};
      end
   end

endmodule

// ===== verif/ansi_sgr_cell_parser_tb.sv =====
module ansi_sgr_cell_parser_tb;

   localparam int SETTLE_CYCLES = 3 * asgr_pkg::MAX_PARAMS + 32;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct packed {
      logic       frame_start;
      logic [7:0] data_byte;
   } text_byte_type;

   // matches rsp_tdata, last field in the lowest bits
   typedef struct packed {
      logic       pad;
      logic [7:0] bg_blue, bg_green, bg_red, fg_blue, fg_green, fg_red, glyph;
      logic [6:0] cell_row;
      logic [7:0] cell_column;
   } cell_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = asgr_pkg::CSR_COLS;
   logic [8:0]  csr_wdata = 9'd0;

   ansi_sgr_cell_parser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   text_byte_type byte_q[$];
   cell_type      cell_q[$];
   text_byte_type next_byte;

   int  err_count = 0;
   int  n_sent = 0;
   int  n_taken = 0;
   int  n_cells = 0;
   int  n_geom = 0;
   int  n_sgr = 0;
   int  cycle_count = 0;
   bit  idle_en = 1'b1;

   // parser state as the block should hold it
   logic [8:0] cfg_cols = asgr_pkg::COLS_RESET;
   logic [7:0] cfg_rows = asgr_pkg::ROWS_RESET;
   int         cur_col, cur_row, accum, pcount;
   logic [23:0] fg, bg;
   asgr_pkg::phase_type scan_phase;
   bit         in_num, halted;
   int         params[asgr_pkg::MAX_PARAMS];

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic report_error(string msg);
      if (err_count < 40)
         $display("ERROR: %s", msg);
      err_count++;
   endtask

   function automatic void clear_frame();
      cur_col = 0;
      cur_row = 0;
      fg = asgr_pkg::FG_DEFAULT;
      bg = asgr_pkg::BG_DEFAULT;
      scan_phase = asgr_pkg::PH_TEXT;
      accum = 0;
      in_num = 1'b0;
      pcount = 0;
      halted = 1'b0;
   endfunction

   function automatic int cols_in_use();
      return (cfg_cols > asgr_pkg::MAX_COLS) ? asgr_pkg::MAX_COLS : int'(cfg_cols);
   endfunction

   function automatic int rows_in_use();
      return (cfg_rows > asgr_pkg::MAX_ROWS) ? asgr_pkg::MAX_ROWS : int'(cfg_rows);
   endfunction

   function automatic void advance_row();
      cur_col = 0;
      cur_row++;
      if (cur_row >= rows_in_use())
         halted = 1'b1;
   endfunction

   function automatic void end_number();
      if (in_num) begin
         if (pcount < asgr_pkg::MAX_PARAMS) begin
            params[pcount] = accum;
            pcount++;
         end
         in_num = 1'b0;
         accum = 0;
      end
   endfunction

   function automatic logic [23:0] rgb_at(int p);
      return {params[p][7:0], params[p+1][7:0], params[p+2][7:0]};
   endfunction

   function automatic void apply_colours();
      int p;
      bit full;
      p = 0;
      while (p < pcount) begin
         full = 1'b0;
         if (p + 4 < pcount)
            full = (params[p+1] == asgr_pkg::SGR_TRUECOLOUR);
         if (params[p] == asgr_pkg::SGR_FG_EXT && full) begin
            fg = rgb_at(p + 2);
            p += 5;
         end else if (params[p] == asgr_pkg::SGR_BG_EXT && full) begin
            bg = rgb_at(p + 2);
            p += 5;
         end else begin
            if (params[p] == asgr_pkg::SGR_RESET) begin
               fg = asgr_pkg::FG_DEFAULT;
               bg = asgr_pkg::BG_DEFAULT;
            end
            p++;
         end
      end
   endfunction

   function automatic void predict_byte(bit fs, logic [7:0] b);
      cell_type c;
      int t, cols;
      if (fs)
         clear_frame();
      if (cur_row >= rows_in_use())
         halted = 1'b1;
      if (halted)
         return;
      if (scan_phase == asgr_pkg::PH_ESC) begin
         if (b == asgr_pkg::CH_LBRACKET) begin
            scan_phase = asgr_pkg::PH_CSI;
            pcount = 0;
            accum = 0;
            in_num = 1'b0;
         end else begin
            scan_phase = asgr_pkg::PH_TEXT;
         end
         return;
      end
      if (scan_phase == asgr_pkg::PH_CSI) begin
         if (b >= asgr_pkg::CH_ZERO && b <= asgr_pkg::CH_NINE) begin
            t = accum * 10 + int'(b - asgr_pkg::CH_ZERO);
            accum = (t > asgr_pkg::NUM_LIMIT) ? int'(asgr_pkg::NUM_LIMIT) : t;
            in_num = 1'b1;
         end else begin
            end_number();
            if (b == asgr_pkg::CH_SGR || b == asgr_pkg::CH_CUP) begin
               if (b == asgr_pkg::CH_SGR)
                  apply_colours();
               scan_phase = asgr_pkg::PH_TEXT;
            end
         end
         return;
      end
      case (b)
         asgr_pkg::CH_ESC: scan_phase = asgr_pkg::PH_ESC;
         asgr_pkg::CH_LF:  advance_row();
         asgr_pkg::CH_CR:  cur_col = 0;
         asgr_pkg::CH_TAB: begin
            t = (cur_col + 8) & ~7;
            cur_col = (t > asgr_pkg::COL_LIMIT) ? int'(asgr_pkg::COL_LIMIT) : t;
         end
         default: begin
            cols = cols_in_use();
            if (cur_col < cols) begin
               c.pad         = 1'b0;
               c.cell_column = cur_col[7:0];
               c.cell_row    = cur_row[6:0];
               c.glyph       = b;
               c.fg_red      = fg[23:16];
               c.fg_green    = fg[15:8];
               c.fg_blue     = fg[7:0];
               c.bg_red      = bg[23:16];
               c.bg_green    = bg[15:8];
               c.bg_blue     = bg[7:0];
               cell_q.insert(cell_q.size(), c);
            end
            if (cur_col < asgr_pkg::COL_LIMIT)
               cur_col++;
            if (cur_col >= cols)
               advance_row();
         end
      endcase
   endfunction

   task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         report_error($sformatf("cell write %0d %s: got %0d, expected %0d",
                                n_cells, name, got, want));
   endtask

   task automatic check_cell(cell_type got);
      cell_type want;
      if (cell_q.size() == 0) begin
         report_error($sformatf("cell write with none expected: %h", got));
         return;
      end
      want = cell_q.pop_front();
      compare_field("cell_column", got.cell_column, want.cell_column);
      compare_field("cell_row", {1'b0, got.cell_row}, {1'b0, want.cell_row});
      compare_field("glyph", got.glyph, want.glyph);
      compare_field("fg_red", got.fg_red, want.fg_red);
      compare_field("fg_green", got.fg_green, want.fg_green);
      compare_field("fg_blue", got.fg_blue, want.fg_blue);
      compare_field("bg_red", got.bg_red, want.bg_red);
      compare_field("bg_green", got.bg_green, want.bg_green);
      compare_field("bg_blue", got.bg_blue, want.bg_blue);
      n_cells++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (byte_q.size() != 0 && !(idle_en && $urandom_range(99) < 11)) begin
            next_byte = byte_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= next_byte.frame_start;
            req_tdata <= next_byte.data_byte;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: predicts on each accepted byte, checks each cell write
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_byte(req_tuser, req_tdata);
            n_taken++;
         end
         if (rsp_tvalid && rsp_tready)
            check_cell(rsp_tdata);
         rsp_tready <= !(idle_en && $urandom_range(99) < 11);
      end
   end

   task automatic push_byte(bit fs, logic [7:0] b);
      text_byte_type entry;
      entry.frame_start = fs;
      entry.data_byte = b;
      byte_q.insert(byte_q.size(), entry);
      n_sent++;
   endtask

   task automatic push_str(string s);
      for (int i = 0; i < s.len(); i++)
         push_byte(1'b0, s[i]);
   endtask

   task automatic push_csi(string body, logic [7:0] term);
      push_byte(1'b0, asgr_pkg::CH_ESC);
      push_byte(1'b0, asgr_pkg::CH_LBRACKET);
      push_str(body);
      push_byte(1'b0, term);
      if (term == asgr_pkg::CH_SGR)
         n_sgr++;
   endtask

   function automatic int colour_value();
      if ($urandom_range(19) == 0)
         return $urandom_range(256, 99999);
      return $urandom_range(255);
   endfunction

   function automatic string sgr_body();
      string s;
      int n;
      s = "";
      n = $urandom_range(1, 4);
      if ($urandom_range(9) == 0)
         n = $urandom_range(5, 20);
      for (int k = 0; k < n; k++) begin
         if (k > 0)
            s = {s, ";"};
         case ($urandom_range(9))
            0, 1, 2: s = {s, $sformatf("38;2;%0d;%0d;%0d",
                                       colour_value(), colour_value(), colour_value())};
            3, 4:    s = {s, $sformatf("48;2;%0d;%0d;%0d",
                                       colour_value(), colour_value(), colour_value())};
            5:       s = {s, "0"};
            6:       s = {s, $sformatf("%0d;2;%0d", $urandom_range(1) ? 38 : 48,
                                       colour_value())};
            7:       s = {s, $sformatf("%0d", $urandom_range(65000, 9999999))};
            8:       s = {s, ""};
            default: s = {s, $sformatf("%0d", $urandom_range(1, 107))};
         endcase
      end
      return s;
   endfunction

   task automatic push_random(int count);
      int sel, n0;
      n0 = n_sent;
      while (n_sent - n0 < count) begin
         sel = $urandom_range(99);
         if (sel < 40) begin
            push_byte($urandom_range(99) < 4, 8'($urandom_range(32, 126)));
         end else if (sel < 48) begin
            push_byte($urandom_range(99) < 4, 8'($urandom_range(255)));
         end else if (sel < 56) begin
            case ($urandom_range(2))
               0:       push_byte(1'b0, asgr_pkg::CH_LF);
               1:       push_byte(1'b0, asgr_pkg::CH_CR);
               default: push_byte(1'b0, asgr_pkg::CH_TAB);
            endcase
         end else if (sel < 76) begin
            push_csi(sgr_body(), asgr_pkg::CH_SGR);
         end else if (sel < 80) begin
            push_csi(sgr_body(), asgr_pkg::CH_CUP);
         end else if (sel < 85) begin
            push_byte(1'b0, asgr_pkg::CH_ESC);
            push_byte(1'b0, 8'($urandom_range(255)));
         end else if (sel < 90) begin
            // sequence with a stray byte inside it
            push_byte(1'b0, asgr_pkg::CH_ESC);
            push_byte(1'b0, asgr_pkg::CH_LBRACKET);
            push_str($sformatf("%0d", $urandom_range(99)));
            push_byte(1'b0, 8'($urandom_range(255)));
            push_str($sformatf("%0d", $urandom_range(99)));
            push_byte(1'b0, asgr_pkg::CH_SGR);
         end else if (sel < 94) begin
            // unterminated sequence, left to whatever follows
            push_byte(1'b0, asgr_pkg::CH_ESC);
            push_byte(1'b0, asgr_pkg::CH_LBRACKET);
            push_str($sformatf("%0d;", $urandom_range(999)));
         end else begin
            push_byte(1'b1, 8'($urandom_range(255)));
         end
      end
   endtask

   task automatic settle();
      while (n_taken != n_sent || cell_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [8:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == asgr_pkg::CSR_COLS)
         cfg_cols = val;
      else
         cfg_rows = val[7:0];
   endtask

   task automatic set_geometry(logic [8:0] cols, logic [8:0] rows);
      write_csr(asgr_pkg::CSR_COLS, cols);
      write_csr(asgr_pkg::CSR_ROWS, rows);
      n_geom++;
   endtask

   initial begin
      clear_frame();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: byte extremes, cursor controls, lone escapes, truecolour
      push_byte(1'b1, "A");
      push_byte(1'b0, 8'h00);
      push_byte(1'b0, 8'hFF);
      push_byte(1'b0, asgr_pkg::CH_TAB);
      push_byte(1'b0, asgr_pkg::CH_CR);
      push_byte(1'b0, asgr_pkg::CH_LF);
      push_byte(1'b0, asgr_pkg::CH_ESC);
      push_byte(1'b0, "q");
      push_byte(1'b0, asgr_pkg::CH_ESC);
      push_byte(1'b0, asgr_pkg::CH_ESC);
      push_byte(1'b0, "c");
      push_csi("38;2;300;1;2", asgr_pkg::CH_SGR);
      push_byte(1'b0, "d");
      settle();

      push_random(100);
      settle();

      set_geometry(9'd1, 9'd1);
      push_random(30);
      settle();

      // no idling here; tab run drives the cursor to its ceiling
      idle_en = 1'b0;
      set_geometry(9'd256, 9'd128);
      push_byte(1'b1, "x");
      repeat (70) push_byte(1'b0, asgr_pkg::CH_TAB);
      push_byte(1'b0, "y");
      push_random(40);
      settle();
      idle_en = 1'b1;

      set_geometry(9'd511, 9'h1C8);
      push_random(60);
      settle();

      set_geometry(9'd0, 9'd4);
      push_byte(1'b1, "z");
      push_random(25);
      settle();

      set_geometry(9'd9, 9'd0);
      push_byte(1'b1, "z");
      push_random(20);
      settle();

      set_geometry(9'($urandom_range(2, 40)), 9'($urandom_range(1, 12)));
      push_random(80);
      settle();

      set_geometry(9'($urandom_range(20, 160)), 9'($urandom_range(2, 60)));
      push_random(80);
      settle();

      $display("sent %0d bytes over %0d geometry settings, %0d sgr sequences",
               n_sent, n_geom, n_sgr);
      $display("checked %0d cell writes", n_cells);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
